// ===== rtl/sim_pkg.sv =====
`default_nettype none

package sim_pkg;

   localparam int COUNT_WIDTH = 16;
   localparam int CFG_WIDTH   = 16;

   localparam logic [CFG_WIDTH-1:0] SAMPLE_PERIOD_RESET    = 16'd50;
   localparam logic [CFG_WIDTH-1:0] WATCHDOG_TIMEOUT_RESET = 16'd1000;

   typedef enum logic [2:0] {
      OP_TICK      = 3'd0,
      OP_START     = 3'd1,
      OP_ARM       = 3'd2,
      OP_DISARM    = 3'd3,
      OP_CLR_ESTOP = 3'd4,
      OP_FEED      = 3'd5
   } opcode_type;

   typedef enum logic [2:0] {
      MODE_DISARMED = 3'd0,
      MODE_ARMED    = 3'd1,
      MODE_MAINT    = 3'd2,
      MODE_ESTOP    = 3'd3,
      MODE_TAMPER   = 3'd4
   } mode_type;

   typedef enum logic {
      REG_SAMPLE_PERIOD    = 1'b0,
      REG_WATCHDOG_TIMEOUT = 1'b1
   } reg_index_type;

   typedef struct packed {
      logic [2:0] opcode;
      logic       arm_pin;
      logic       estop_pin;
      logic       tamper_pin;
      logic       maint_pin;
   } item_type;

   typedef struct packed {
      logic [CFG_WIDTH-1:0] sample_period_ticks;
      logic [CFG_WIDTH-1:0] watchdog_timeout_ticks;
   } cfg_type;

   typedef struct packed {
      logic [2:0] mode;
      logic       actuate_ok;
      logic       watchdog_good;
      logic       estop_is_latched;
      logic       tamper_seen;
      logic       sampled;
   } result_type;

endpackage

`default_nettype wire

// ===== rtl/sim_core.sv =====
`default_nettype none

module sim_core (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               advance,
   input  wire sim_pkg::item_type  item,
   input  wire sim_pkg::cfg_type   cfg,
   output      sim_pkg::result_type result
);

   sim_pkg::mode_type                 mode_ff, mode_in;
   logic                              latch_ff, latch_in;
   logic                              tamper_ff, tamper_in;
   logic                              arm_ff, arm_in;
   logic                              maint_ff, maint_in;
   logic [sim_pkg::COUNT_WIDTH-1:0]   sample_cnt_ff, sample_cnt_in;
   logic [sim_pkg::COUNT_WIDTH-1:0]   feed_cnt_ff, feed_cnt_in;
   logic [sim_pkg::COUNT_WIDTH-1:0]   sample_inc;
   logic                              do_sample;
   logic                              do_choose;

   always_comb begin
      mode_in       = mode_ff;
      latch_in      = latch_ff;
      tamper_in     = tamper_ff;
      arm_in        = arm_ff;
      maint_in      = maint_ff;
      sample_cnt_in = sample_cnt_ff;
      feed_cnt_in   = feed_cnt_ff;
      sample_inc    = sample_cnt_ff + 1'b1;
      do_sample     = 1'b0;
      do_choose     = 1'b0;

      case (item.opcode)
         sim_pkg::OP_TICK: begin
            // watchdog count saturates at the timeout
            if (32'(feed_cnt_ff) < 32'(cfg.watchdog_timeout_ticks)) begin
               feed_cnt_in = feed_cnt_ff + 1'b1;
            end
            sample_cnt_in = sample_inc;
            if (32'(sample_inc) >= 32'(cfg.sample_period_ticks)) begin
               sample_cnt_in = '0;
               do_sample     = 1'b1;
            end
         end
         sim_pkg::OP_START: begin
            sample_cnt_in = '0;
            feed_cnt_in   = '0;
            do_sample     = 1'b1;
         end
         sim_pkg::OP_ARM: begin
            if (!latch_ff && !tamper_ff) begin
               mode_in = sim_pkg::MODE_ARMED;
            end
         end
         sim_pkg::OP_DISARM: begin
            if (mode_ff == sim_pkg::MODE_ARMED) begin
               mode_in = sim_pkg::MODE_DISARMED;
            end
         end
         sim_pkg::OP_CLR_ESTOP: begin
            latch_in  = 1'b0;
            do_choose = 1'b1;
         end
         sim_pkg::OP_FEED: begin
            feed_cnt_in = '0;
         end
         default: begin
         end
      endcase

      if (do_sample) begin
         latch_in  = latch_ff | item.estop_pin;
         tamper_in = item.tamper_pin;
         arm_in    = item.arm_pin;
         maint_in  = item.maint_pin;
         do_choose = 1'b1;
      end

      // priority: e-stop, tamper, maintenance, then the arm level
      if (do_choose) begin
         if (latch_in) begin
            mode_in = sim_pkg::MODE_ESTOP;
         end else if (tamper_in) begin
            mode_in = sim_pkg::MODE_TAMPER;
         end else if (maint_in) begin
            mode_in = sim_pkg::MODE_MAINT;
         end else if (arm_in) begin
            mode_in = sim_pkg::MODE_ARMED;
         end else begin
            mode_in = sim_pkg::MODE_DISARMED;
         end
      end

      result.mode             = mode_in;
      result.actuate_ok       = (mode_in == sim_pkg::MODE_ARMED);
      result.watchdog_good    = (32'(feed_cnt_in) < 32'(cfg.watchdog_timeout_ticks));
      result.estop_is_latched = latch_in;
      result.tamper_seen      = tamper_in;
      result.sampled          = do_sample;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= sim_pkg::MODE_DISARMED;
         latch_ff      <= 1'b0;
         tamper_ff     <= 1'b0;
         arm_ff        <= 1'b0;
         maint_ff      <= 1'b0;
         sample_cnt_ff <= '0;
         feed_cnt_ff   <= '0;
      end else if (advance) begin
         mode_ff       <= mode_in;
         latch_ff      <= latch_in;
         tamper_ff     <= tamper_in;
         arm_ff        <= arm_in;
         maint_ff      <= maint_in;
         sample_cnt_ff <= sample_cnt_in;
         feed_cnt_ff   <= feed_cnt_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/safety_interlock_mode_control_unit.sv =====
`default_nettype none

// Safety interlock mode control. Each request is a tick, a start or a software
// command (arm, disarm, clear e-stop, feed watchdog) together with the four switch
// levels; every request yields exactly one response carrying the new mode and status.
// A request is captured in an input register, the mode and counter update is done in
// combinational logic, and the response is held in an output register, so one request
// is taken per clock while req_stall is low; a request passes the input register and
// then the output register before its response shows on the response port. The block
// keeps taking requests while a response waits as long as the input register is free;
// req_stall rises only when both registers are full and the response side stalls. The
// sample period and watchdog timeout live at byte addresses 0 and 4 of the csr port and
// should be written while no request is in flight.

module safety_interlock_mode_control_unit (
   input  wire logic        clock,
   input  wire logic        reset,

   input  wire logic        req_valid,
   output      logic        req_stall,
   input  wire logic [2:0]  req_opcode,
   input  wire logic        req_arm_pin,
   input  wire logic        req_estop_pin,
   input  wire logic        req_tamper_pin,
   input  wire logic        req_maint_pin,

   output      logic        rsp_valid,
   input  wire logic        rsp_stall,
   output      logic [2:0]  rsp_mode,
   output      logic        rsp_actuate_ok,
   output      logic        rsp_watchdog_good,
   output      logic        rsp_estop_is_latched,
   output      logic        rsp_tamper_seen,
   output      logic        rsp_sampled,

   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output      logic [31:0] csr_prdata,
   output      logic        csr_pready
);

   sim_pkg::cfg_type    cfg_ff;
   sim_pkg::item_type   item_ff;
   logic                item_valid_ff;
   sim_pkg::result_type result;
   sim_pkg::result_type rsp_ff;
   logic                rsp_valid_ff;
   logic                out_free;
   logic                advance;
   logic                req_take;
   logic                csr_write;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign advance   = item_valid_ff && out_free;
   assign req_stall = item_valid_ff && !out_free;
   assign req_take  = req_valid && !req_stall;

   // configuration registers
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sample_period_ticks    <= sim_pkg::SAMPLE_PERIOD_RESET;
         cfg_ff.watchdog_timeout_ticks <= sim_pkg::WATCHDOG_TIMEOUT_RESET;
      end else if (csr_write) begin
         case (csr_paddr[2])
            sim_pkg::REG_SAMPLE_PERIOD: begin
               cfg_ff.sample_period_ticks <= csr_pwdata[sim_pkg::CFG_WIDTH-1:0];
            end
            sim_pkg::REG_WATCHDOG_TIMEOUT: begin
               cfg_ff.watchdog_timeout_ticks <= csr_pwdata[sim_pkg::CFG_WIDTH-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[2])
         sim_pkg::REG_SAMPLE_PERIOD:    csr_prdata = 32'(cfg_ff.sample_period_ticks);
         sim_pkg::REG_WATCHDOG_TIMEOUT: csr_prdata = 32'(cfg_ff.watchdog_timeout_ticks);
         default:                       csr_prdata = '0;
      endcase
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else if (req_take) begin
         item_valid_ff <= 1'b1;
      end else if (advance) begin
         item_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         item_ff.opcode     <= req_opcode;
         item_ff.arm_pin    <= req_arm_pin;
         item_ff.estop_pin  <= req_estop_pin;
         item_ff.tamper_pin <= req_tamper_pin;
         item_ff.maint_pin  <= req_maint_pin;
      end
   end

   sim_core u_core (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .item    (item_ff),
      .cfg     (cfg_ff),
      .result  (result)
   );

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= advance;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_mode             = rsp_ff.mode;
   assign rsp_actuate_ok       = rsp_ff.actuate_ok;
   assign rsp_watchdog_good    = rsp_ff.watchdog_good;
   assign rsp_estop_is_latched = rsp_ff.estop_is_latched;
   assign rsp_tamper_seen      = rsp_ff.tamper_seen;
   assign rsp_sampled          = rsp_ff.sampled;

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_mode == sim_pkg::MODE_ESTOP |-> rsp_estop_is_latched)
      else $error("e-stop mode without latched e-stop");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_actuate_ok |-> !rsp_estop_is_latched && !rsp_tamper_seen)
      else $error("actuation allowed with e-stop or tamper set");

   assert property (@(posedge clock) disable iff (reset)
      item_valid_ff && !out_free |=> item_valid_ff && $stable(item_ff))
      else $error("stalled request lost in input register");

   assert property (@(posedge clock)
      reset |=> !rsp_valid && !item_valid_ff)
      else $error("pipeline not empty after reset");

endmodule

`default_nettype wire
